### hdl/otg_pkg.sv
// Shared types, constants and the 6x8 font table for the text glyph emitter.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package otg_pkg;

   // Printable glyph range held by the font table.
   localparam logic [6:0] GLYPH_FIRST = 7'd32;
   localparam logic [6:0] GLYPH_LAST  = 7'd123;

   // Command byte bases.
   localparam logic [7:0] CMD_PAGE   = 8'hB0;
   localparam logic [7:0] CMD_COL_LO = 8'h00;
   localparam logic [7:0] CMD_COL_HI = 8'h10;

   // Page count limits and run shape.
   localparam logic [3:0] PAGES_MIN  = 4'd1;
   localparam logic [3:0] PAGES_MAX  = 4'd8;
   localparam logic [3:0] CMD_BYTES  = 4'd3;
   localparam logic [3:0] LAST_BYTE  = 4'd8;
   localparam logic [7:0] GLYPH_STEP = 8'd6;
   localparam logic [5:0] LINE_STEP  = 6'd8;

   // Cursor as kept in the state memory.
   typedef struct packed {
      logic [7:0] col;
      logic [5:0] row;
   } cursor_type;

   // One character run handed from the cursor stage to the byte emitter.
   typedef struct packed {
      logic [7:0] page_cmd;
      logic [7:0] col_lo_cmd;
      logic [7:0] col_hi_cmd;
      logic [6:0] glyph_idx;
   } job_type;

   // Six glyph columns, first column in the top byte.
   function automatic logic [47:0] font_glyph(input logic [6:0] idx);
      logic [47:0] g;
      begin
         case (idx)
            7'd0:  g = 48'h000000000000;
            7'd1:  g = 48'h0000002f0000;
            7'd2:  g = 48'h000007000700;
            7'd3:  g = 48'h00147f147f14;
            7'd4:  g = 48'h00242a7f2a12;
            7'd5:  g = 48'h006264081323;
            7'd6:  g = 48'h003649552250;
            7'd7:  g = 48'h000005030000;
            7'd8:  g = 48'h00001c224100;
            7'd9:  g = 48'h000041221c00;
            7'd10: g = 48'h0014083E0814;
            7'd11: g = 48'h0008083E0808;
            7'd12: g = 48'h000000A06000;
            7'd13: g = 48'h000808080808;
            7'd14: g = 48'h000060600000;
            7'd15: g = 48'h002010080402;
            7'd16: g = 48'h003E5149453E;
            7'd17: g = 48'h0000427F4000;
            7'd18: g = 48'h004261514946;
            7'd19: g = 48'h002141454B31;
            7'd20: g = 48'h001814127F10;
            7'd21: g = 48'h002745454539;
            7'd22: g = 48'h003C4A494930;
            7'd23: g = 48'h000171090503;
            7'd24: g = 48'h003649494936;
            7'd25: g = 48'h00064949291E;
            7'd26: g = 48'h000036360000;
            7'd27: g = 48'h000056360000;
            7'd28: g = 48'h000814224100;
            7'd29: g = 48'h001414141414;
            7'd30: g = 48'h000041221408;
            7'd31: g = 48'h000201510906;
            7'd32: g = 48'h00324959513E;
            7'd33: g = 48'h007C1211127C;
            7'd34: g = 48'h007F49494936;
            7'd35: g = 48'h003E41414122;
            7'd36: g = 48'h007F4141221C;
            7'd37: g = 48'h007F49494941;
            7'd38: g = 48'h007F09090901;
            7'd39: g = 48'h003E4149497A;
            7'd40: g = 48'h007F0808087F;
            7'd41: g = 48'h0000417F4100;
            7'd42: g = 48'h002040413F01;
            7'd43: g = 48'h007F08142241;
            7'd44: g = 48'h007F40404040;
            7'd45: g = 48'h007F020C027F;
            7'd46: g = 48'h007F0408107F;
            7'd47: g = 48'h003E4141413E;
            7'd48: g = 48'h007F09090906;
            7'd49: g = 48'h003E4151215E;
            7'd50: g = 48'h007F09192946;
            7'd51: g = 48'h004649494931;
            7'd52: g = 48'h0001017F0101;
            7'd53: g = 48'h003F4040403F;
            7'd54: g = 48'h001F2040201F;
            7'd55: g = 48'h003F4038403F;
            7'd56: g = 48'h006314081463;
            7'd57: g = 48'h000708700807;
            7'd58: g = 48'h006151494543;
            7'd59: g = 48'h00007F414100;
            7'd60: g = 48'h00552A552A55;
            7'd61: g = 48'h000041417F00;
            7'd62: g = 48'h000402010204;
            7'd63: g = 48'h004040404040;
            7'd64: g = 48'h000001020400;
            7'd65: g = 48'h002054545478;
            7'd66: g = 48'h007F48444438;
            7'd67: g = 48'h003844444420;
            7'd68: g = 48'h00384444487F;
            7'd69: g = 48'h003854545418;
            7'd70: g = 48'h00087E090102;
            7'd71: g = 48'h0018A4A4A47C;
            7'd72: g = 48'h007F08040478;
            7'd73: g = 48'h0000447D4000;
            7'd74: g = 48'h004080847D00;
            7'd75: g = 48'h007F10284400;
            7'd76: g = 48'h0000417F4000;
            7'd77: g = 48'h007C04180478;
            7'd78: g = 48'h007C08040478;
            7'd79: g = 48'h003844444438;
            7'd80: g = 48'h00FC24242418;
            7'd81: g = 48'h0018242418FC;
            7'd82: g = 48'h007C08040408;
            7'd83: g = 48'h004854545420;
            7'd84: g = 48'h00043F444020;
            7'd85: g = 48'h003C4040207C;
            7'd86: g = 48'h001C2040201C;
            7'd87: g = 48'h003C4030403C;
            7'd88: g = 48'h004428102844;
            7'd89: g = 48'h001CA0A0A07C;
            7'd90: g = 48'h004464544C44;
            7'd91: g = 48'h141414141414;
            default: g = 48'h000000000000;
         endcase
         return g;
      end
   endfunction

endpackage

`default_nettype wire

### hdl/otg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module otg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/otg_cursor.sv
// Cursor stage: reads the cursor from the state memory, updates it and writes it back,
// and hands each printable character to the byte emitter. Uses otg_pkg and otg_ram.
`default_nettype none

module otg_cursor #(
   parameter int DISPLAY_COLUMNS = 128,
   parameter int CELLS_PER_LINE  = 21
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [3:0]       page_count,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_mode,
   input  wire logic [6:0]       req_code,
   input  wire logic [7:0]       req_cell,
   output logic                  job_valid,
   input  wire logic             job_ready,
   output otg_pkg::job_type      job
);

   localparam int CUR_W = $bits(otg_pkg::cursor_type);

   logic                 init_ff;
   logic                 b_valid_ff, b_valid_in;
   logic                 b_mode_ff;
   logic [6:0]           b_code_ff;
   logic [7:0]           b_cell_ff;

   logic                 accept;
   logic                 b_done;
   logic                 printable;
   logic [3:0]           eff_pages;
   logic [7:0]           total_cells;
   logic [7:0]           cell_clamped;
   logic [7:0]           rem;
   logic [2:0]           quo;
   logic [8:0]           col_sum;
   logic [6:0]           row_sum;
   logic [6:0]           row_limit;
   otg_pkg::cursor_type  cur;
   otg_pkg::cursor_type  cur_next;
   logic                 wr_en;
   logic [CUR_W-1:0]     wr_data;
   logic [CUR_W-1:0]     rd_data;

   // Handshake: one item in the update stage at a time; none during the clearing cycle.
   assign req_ready = !init_ff && !b_valid_ff;
   assign accept    = req_valid && req_ready;

   assign printable = (b_code_ff >= otg_pkg::GLYPH_FIRST) && (b_code_ff <= otg_pkg::GLYPH_LAST);
   assign job_valid = b_valid_ff && !b_mode_ff && printable;
   assign b_done    = b_valid_ff && (!job_valid || job_ready);
   assign b_valid_in = accept ? 1'b1 : (b_done ? 1'b0 : b_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= 1'b1;
         b_valid_ff <= 1'b0;
      end else begin
         init_ff    <= 1'b0;
         b_valid_ff <= b_valid_in;
      end
   end

   // Item payload held for the update stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         b_mode_ff <= req_mode;
         b_code_ff <= req_code;
         b_cell_ff <= req_cell;
      end
   end

   // State memory holding the cursor in entry zero.
   otg_ram #(
      .WIDTH (CUR_W),
      .DEPTH (2)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (1'b0),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (1'b0),
      .rd_data (rd_data)
   );

   assign cur = otg_pkg::cursor_type'(rd_data);

   // Page count, with zero read as one and large values read as eight.
   always_comb begin
      if (page_count < otg_pkg::PAGES_MIN) begin
         eff_pages = otg_pkg::PAGES_MIN;
      end else if (page_count > otg_pkg::PAGES_MAX) begin
         eff_pages = otg_pkg::PAGES_MAX;
      end else begin
         eff_pages = page_count;
      end
   end

   // Cursor set: clamp the cell, then split it into line and cell within the line.
   always_comb begin
      total_cells  = 8'(CELLS_PER_LINE) * {4'b0000, eff_pages};
      cell_clamped = (b_cell_ff >= total_cells) ? total_cells - 8'd1 : b_cell_ff;
      rem = cell_clamped;
      quo = 3'b000;
      for (int k = 2; k >= 0; k--) begin
         if ({1'b0, rem} >= 9'(CELLS_PER_LINE << k)) begin
            rem    = rem - 8'(CELLS_PER_LINE << k);
            quo[k] = 1'b1;
         end
      end
   end

   // Cursor set, or character advance with line and page wrap.
   assign col_sum   = {1'b0, cur.col} + {1'b0, otg_pkg::GLYPH_STEP};
   assign row_sum   = {1'b0, cur.row} + {1'b0, otg_pkg::LINE_STEP};
   assign row_limit = {eff_pages, 3'b000};

   always_comb begin
      cur_next = cur;
      if (b_mode_ff) begin
         cur_next.col = (rem << 2) + (rem << 1);
         cur_next.row = {quo, 3'b000};
      end else if (col_sum >= 9'(DISPLAY_COLUMNS)) begin
         cur_next.col = 8'd0;
         cur_next.row = (row_sum >= row_limit) ? 6'd0 : row_sum[5:0];
      end else begin
         cur_next.col = col_sum[7:0];
      end
   end

   // Write back: zero once after reset, then the updated cursor.
   assign wr_en   = init_ff || (b_done && (b_mode_ff || printable));
   assign wr_data = init_ff ? '0 : CUR_W'(cur_next);

   // Command bytes and glyph index for the emitter.
   always_comb begin
      job.page_cmd   = otg_pkg::CMD_PAGE + {5'b00000, cur.row[5:3]};
      job.col_lo_cmd = otg_pkg::CMD_COL_LO + {4'b0000, cur.col[3:0]};
      job.col_hi_cmd = otg_pkg::CMD_COL_HI + {4'b0000, cur.col[7:4]};
      job.glyph_idx  = b_code_ff - otg_pkg::GLYPH_FIRST;
   end

endmodule

`default_nettype wire

### hdl/otg_emitter.sv
// Byte emitter: turns one character run into nine beats on the result channel.
// Uses otg_pkg for the run layout and the font table.
`default_nettype none

module otg_emitter (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output logic                  job_ready,
   input  wire otg_pkg::job_type job,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_byte,
   output logic                  rsp_is_data,
   output logic                  rsp_last
);

   logic        valid_ff, valid_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [71:0] shift_ff, shift_in;
   logic        beat;
   logic        run_end;
   logic        load;

   assign beat      = valid_ff && rsp_ready;
   assign run_end   = cnt_ff == otg_pkg::LAST_BYTE;
   assign job_ready = !valid_ff || (beat && run_end);
   assign load      = job_valid && job_ready;

   // Sequencer: load a run, shift one byte per beat, drop valid after the last.
   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      if (load) begin
         valid_in = 1'b1;
         cnt_in   = 4'd0;
         shift_in = {job.page_cmd, job.col_lo_cmd, job.col_hi_cmd,
                     otg_pkg::font_glyph(job.glyph_idx)};
      end else if (beat) begin
         valid_in = !run_end;
         cnt_in   = cnt_ff + 4'd1;
         shift_in = {shift_ff[63:0], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_byte    = shift_ff[71:64];
   assign rsp_is_data = cnt_ff >= otg_pkg::CMD_BYTES;
   assign rsp_last    = run_end;

endmodule

`default_nettype wire

### hdl/oled_text_glyph_emitter.sv
// A character passes the cursor stage register, then the emitter's shift register.
// Throughput: one result byte per cycle on rsp while rsp_tready is high.
// A cursor set reads, then writes the state memory; a non-printable code only reads it.
// Reset: synchronous; the cycle after reset clears the cursor entry, req_tready low then.
// Page count resets to 8; the config port is always ready.
`default_nettype none

module oled_text_glyph_emitter #(
   parameter int DISPLAY_COLUMNS = 128,
   parameter int CELLS_PER_LINE  = 21
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration write channel: page_count.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_wdata,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [6:0] char_code, [14:7] cell_index, [15] zero
   input  wire logic        req_tuser,  // [0] mode
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // [7:0] byte_out
   output logic             rsp_tuser,  // [0] is_data
   output logic             rsp_tlast   // last
);

   logic [3:0]       page_count_ff;
   logic             job_valid;
   logic             job_ready;
   otg_pkg::job_type job;

   // Page count register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= otg_pkg::PAGES_MAX;
      end else if (csr_valid) begin
         page_count_ff <= csr_wdata;
      end
   end

   otg_cursor #(
      .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
      .CELLS_PER_LINE  (CELLS_PER_LINE)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .page_count (page_count_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_mode   (req_tuser),
      .req_code   (req_tdata[6:0]),
      .req_cell   (req_tdata[14:7]),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   otg_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_byte    (rsp_tdata),
      .rsp_is_data (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

endmodule

`default_nettype wire
